// ===== hw/rtl/gcgd_pkg.sv =====
// Shared types, constants and helpers of the grid corner guide detector.
// Depends on nothing; every other file of the block imports it.
package gcgd_pkg;

  localparam int DATA_W      = 64;
  localparam int ROW_W       = 10;
  localparam int TOTAL_W     = 17;
  localparam int CFG_W       = 7;
  localparam int GRP_W       = 8;
  localparam int GROUPS      = DATA_W / GRP_W;
  localparam int GCNT_W      = 4;
  localparam int SUM_W       = 7;

  localparam int DEF_MAX_WIDTH = 64;
  localparam int DEF_MAX_ROWS  = 1024;
  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(64);

  // Result queue geometry.
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;

  // Bits one cell hands to each of its two neighbors.
  typedef struct packed {
    logic mf_a;   // middle row free
    logic ub_a;   // row above blocked
    logic db_a;   // incoming row blocked
    logic mf_b;   // incoming row free
    logic ub_b;   // middle row blocked
  } nbr_t;

  // One result item.
  typedef struct packed {
    logic [DATA_W-1:0]  guide_mask;
    logic [ROW_W-1:0]   row_number;
    logic [TOTAL_W-1:0] guide_total;
    logic               final_result;
  } res_t;

  // Up to two results caused by one row, in order: first ra, then rb.
  typedef struct packed {
    logic va;
    logic vb;
    res_t ra;
    res_t rb;
  } pair_t;

  // Number of set bits in one group of the mask.
  function automatic logic [GCNT_W-1:0] pop_group(input logic [GRP_W-1:0] v);
    logic [GCNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < GRP_W; k++) begin
      n = n + GCNT_W'(v[k]);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/gcgd_row_if.sv =====
// Row input channel of the grid corner guide detector.
// Depends on gcgd_pkg for the field widths.
interface gcgd_row_if import gcgd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] row_obstacles;
  logic              last_row;

  modport source (output valid, output row_obstacles, output last_row, input ready);
  modport sink (input valid, input row_obstacles, input last_row, output ready);
endinterface

// ===== hw/rtl/gcgd_res_if.sv =====
// Result channel of the grid corner guide detector.
// Depends on gcgd_pkg for the field widths.
interface gcgd_res_if import gcgd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  guide_mask;
  logic [ROW_W-1:0]   row_number;
  logic [TOTAL_W-1:0] guide_total;
  logic               final_result;

  modport source (output valid, output guide_mask, output row_number,
                  output guide_total, output final_result, input ready);
  modport sink (input valid, input guide_mask, input row_number,
                input guide_total, input final_result, output ready);
endinterface

// ===== hw/rtl/gcgd_cell.sv =====
// One column cell: holds the column's bits of the two stored rows and
// tests the corner rule against its left and right neighbors. Uses gcgd_pkg.
module gcgd_cell import gcgd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic shift,      // a row is transferred in
  input  logic clear,      // the grid ends with this row
  input  logic col_en,     // column lies inside the grid width
  input  logic has_up,     // the row above the middle row exists
  input  logic cur_bit,    // incoming row, this column
  input  nbr_t nbr_lo,     // from column i-1
  input  nbr_t nbr_hi,     // from column i+1
  output nbr_t nbr_out,
  output logic guide_a,    // guide bit of the middle row
  output logic guide_b     // guide bit of the incoming row, as a last row
);

  logic above_r, above_nxt;
  logic middle_r, middle_nxt;
  logic above_f, above_b, mid_f, mid_b, cur_f, cur_b;
  logic up_hit, down_hit;

  // Cells outside the width count as neither free nor blocked.
  assign above_f = ~above_r & col_en;
  assign above_b = above_r & col_en;
  assign mid_f   = ~middle_r & col_en;
  assign mid_b   = middle_r & col_en;
  assign cur_f   = ~cur_bit & col_en;
  assign cur_b   = cur_bit & col_en;

  assign nbr_out = '{mf_a: mid_f, ub_a: above_b, db_a: cur_b, mf_b: cur_f, ub_b: mid_b};

  // Middle row: corner toward the row above or the incoming row below.
  assign up_hit   = has_up & above_f &
                    ((nbr_lo.mf_a & nbr_lo.ub_a) | (nbr_hi.mf_a & nbr_hi.ub_a));
  assign down_hit = cur_f &
                    ((nbr_lo.mf_a & nbr_lo.db_a) | (nbr_hi.mf_a & nbr_hi.db_a));
  assign guide_a  = mid_f & (up_hit | down_hit);

  // Incoming row as the last row: only the middle row lies above it.
  assign guide_b = cur_f & mid_f &
                   ((nbr_lo.mf_b & nbr_lo.ub_b) | (nbr_hi.mf_b & nbr_hi.ub_b));

  // Rows move down one place per transfer; the end of a grid empties them.
  always_comb begin
    above_nxt  = above_r;
    middle_nxt = middle_r;
    if (shift) begin
      above_nxt  = clear ? 1'b0 : middle_r;
      middle_nxt = clear ? 1'b0 : cur_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r  <= 1'b0;
      middle_r <= 1'b0;
    end else begin
      above_r  <= above_nxt;
      middle_r <= middle_nxt;
    end
  end

endmodule

// ===== hw/rtl/gcgd_tally.sv =====
// Guide counting: group popcounts in one stage, then the group sum and the
// saturating running total of the grid. Uses gcgd_pkg.
module gcgd_tally import gcgd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pair_t       pair_in,     // masks from the cell row, totals unset
  output pair_t       pair_out,    // complete results, to the queue
  output logic [1:0]  busy         // results held in the popcount stage
);

  pair_t             stg_b_r;
  logic [GCNT_W-1:0] grp_a_r [GROUPS];
  logic [GCNT_W-1:0] grp_b_r [GROUPS];
  logic [TOTAL_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]  sum_a, sum_b;
  logic [TOTAL_W:0]  raw_a, raw_b;
  logic [TOTAL_W-1:0] tot_a, tot_b;

  assign busy = {stg_b_r.vb, stg_b_r.va};

  // Popcount stage: one count per group of bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_b_r.va <= 1'b0;
      stg_b_r.vb <= 1'b0;
    end else begin
      stg_b_r <= pair_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_a_r[g] <= pop_group(pair_in.ra.guide_mask[g*GRP_W +: GRP_W]);
      grp_b_r[g] <= pop_group(pair_in.rb.guide_mask[g*GRP_W +: GRP_W]);
    end
  end

  // Sum of the group counts.
  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_a = sum_a + SUM_W'(grp_a_r[g]);
      sum_b = sum_b + SUM_W'(grp_b_r[g]);
    end
  end

  // Running total, saturating; the second result builds on the first.
  always_comb begin
    raw_a = {1'b0, count_r} + (TOTAL_W+1)'(stg_b_r.va ? sum_a : '0);
    tot_a = raw_a[TOTAL_W] ? COUNT_MAX : raw_a[TOTAL_W-1:0];
    raw_b = {1'b0, tot_a} + (TOTAL_W+1)'(sum_b);
    tot_b = raw_b[TOTAL_W] ? COUNT_MAX : raw_b[TOTAL_W-1:0];
  end

  // A final result closes the grid and the total starts over.
  always_comb begin
    count_nxt = count_r;
    if (stg_b_r.vb) begin
      count_nxt = '0;
    end else if (stg_b_r.va) begin
      count_nxt = tot_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    pair_out                = stg_b_r;
    pair_out.ra.guide_total = tot_a;
    pair_out.rb.guide_total = tot_b;
  end

endmodule

// ===== hw/rtl/gcgd_queue.sv =====
// Result queue: takes up to two results a cycle and offers one a cycle on
// the output channel while it is ready. Uses gcgd_pkg and gcgd_res_if.
module gcgd_queue import gcgd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pair_t             pair_in,
  output logic [QCNT_W-1:0] fill,
  gcgd_res_if.source        out_ch
);

  res_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_b;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              rd;
  res_t              head;

  assign fill = cnt_r;
  assign head = mem_r[rp_r];
  assign rd   = out_ch.valid & out_ch.ready;

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.guide_mask   = head.guide_mask;
  assign out_ch.row_number   = head.row_number;
  assign out_ch.guide_total  = head.guide_total;
  assign out_ch.final_result = head.final_result;

  // Second result goes right behind the first when both are written.
  assign wp_b = wp_r + QPTR_W'(pair_in.va);

  always_ff @(posedge clk) begin
    if (pair_in.va) begin
      mem_r[wp_r] <= pair_in.ra;
    end
    if (pair_in.vb) begin
      mem_r[wp_b] <= pair_in.rb;
    end
  end

  // Pointer and fill bookkeeping.
  always_comb begin
    wp_nxt  = wp_r + QPTR_W'(pair_in.va) + QPTR_W'(pair_in.vb);
    rp_nxt  = rp_r + QPTR_W'(rd);
    cnt_nxt = cnt_r + QCNT_W'(pair_in.va) + QCNT_W'(pair_in.vb) - QCNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // The space reservation upstream must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // A result written into an empty queue is offered in the next cycle.
  a_write_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 && (pair_in.va || pair_in.vb)) |=> out_ch.valid)
    else $error("written result not offered");

endmodule

// ===== hw/rtl/grid_corner_guide_detector.sv =====
// Grid corner guide detector, top level. Uses gcgd_pkg, both channel
// interfaces, gcgd_cell, gcgd_tally and gcgd_queue.
// A result is registered in the mask stage, popcount stage and queue in turn.
// Throughput: one row per cycle while in_ch.ready is high; a last row puts two
// results into the 8-entry queue, which drains one per cycle of out_ch.ready.
// Reset (synchronous, rst_n low) empties rows, counters and queue; width is 64.
module grid_corner_guide_detector import gcgd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
  input  logic             clk,
  input  logic             rst_n,
  gcgd_row_if.sink         in_ch,
  gcgd_res_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int RW = $clog2(MAX_ROWS);

  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   width_eff;
  logic [RW-1:0]      idx_r, idx_nxt;
  logic               acc, last, has_up;
  logic [TOTAL_W-1:0] idx_ext, idx_prev;
  logic [MAX_WIDTH-1:0] col_en, ga, gb;
  nbr_t               nbr [MAX_WIDTH];
  nbr_t               nbr_lo [MAX_WIDTH];
  nbr_t               nbr_hi [MAX_WIDTH];
  pair_t              stg_a_r, stg_a_nxt, tally_out;
  logic [1:0]         tally_busy;
  logic [QCNT_W-1:0]  q_fill;
  logic [QCNT_W:0]    pending;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
    end
  end

  // Width clamped to the range the cell row supports.
  always_comb begin
    if (width_r == '0) begin
      width_eff = CFG_W'(1);
    end else if (width_r > CFG_W'(MAX_WIDTH)) begin
      width_eff = CFG_W'(MAX_WIDTH);
    end else begin
      width_eff = width_r;
    end
  end

  // Results in flight must all fit into the queue: two per last row.
  assign pending = (QCNT_W+1)'(q_fill) + (QCNT_W+1)'(stg_a_r.va) + (QCNT_W+1)'(stg_a_r.vb)
                 + (QCNT_W+1)'(tally_busy[0]) + (QCNT_W+1)'(tally_busy[1]);
  assign in_ch.ready = (pending <= (QCNT_W+1)'(QUEUE_DEPTH - 2));

  assign acc    = in_ch.valid & in_ch.ready;
  assign last   = in_ch.last_row | (idx_r == RW'(MAX_ROWS - 1));
  assign has_up = (idx_r > RW'(1));

  // Row index within the grid.
  assign idx_nxt = acc ? (last ? '0 : idx_r + RW'(1)) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Row of column cells, each wired to its two neighbors.
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col
    assign col_en[i] = (CFG_W'(i) < width_eff);
    if (i == 0) begin : g_lo_edge
      assign nbr_lo[i] = '0;
    end else begin : g_lo
      assign nbr_lo[i] = nbr[i-1];
    end
    if (i == MAX_WIDTH - 1) begin : g_hi_edge
      assign nbr_hi[i] = '0;
    end else begin : g_hi
      assign nbr_hi[i] = nbr[i+1];
    end

    gcgd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (acc),
      .clear   (last),
      .col_en  (col_en[i]),
      .has_up  (has_up),
      .cur_bit (in_ch.row_obstacles[i]),
      .nbr_lo  (nbr_lo[i]),
      .nbr_hi  (nbr_hi[i]),
      .nbr_out (nbr[i]),
      .guide_a (ga[i]),
      .guide_b (gb[i])
    );
  end

  // Mask stage: the middle row's result, and the incoming row's on a last row.
  always_comb begin
    idx_ext  = TOTAL_W'(idx_r);
    idx_prev = idx_ext - TOTAL_W'(1);
    stg_a_nxt                 = '0;
    stg_a_nxt.va              = acc & (idx_r != '0);
    stg_a_nxt.vb              = acc & last;
    stg_a_nxt.ra.guide_mask   = DATA_W'(ga);
    stg_a_nxt.ra.row_number   = idx_prev[ROW_W-1:0];
    stg_a_nxt.ra.final_result = 1'b0;
    stg_a_nxt.rb.guide_mask   = (idx_r == '0) ? '0 : DATA_W'(gb);
    stg_a_nxt.rb.row_number   = idx_ext[ROW_W-1:0];
    stg_a_nxt.rb.final_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_a_r.va <= 1'b0;
      stg_a_r.vb <= 1'b0;
    end else begin
      stg_a_r <= stg_a_nxt;
    end
  end

  gcgd_tally u_tally (
    .clk      (clk),
    .rst_n    (rst_n),
    .pair_in  (stg_a_r),
    .pair_out (tally_out),
    .busy     (tally_busy)
  );

  gcgd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .pair_in (tally_out),
    .fill    (q_fill),
    .out_ch  (out_ch)
  );

  // A last row ends the grid: the next row is row zero again.
  a_grid_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last) |=> (idx_r == '0))
    else $error("row index not restarted after last row");

  // The first row of a longer grid gives no result.
  a_first_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && idx_r == '0 && !last) |=> (!stg_a_r.va && !stg_a_r.vb))
    else $error("first row produced a result");

  // A one-row grid reports an empty mask.
  a_single_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_a_r.vb && !stg_a_r.va) |-> (stg_a_r.rb.guide_mask == '0))
    else $error("one-row grid reported guides");

endmodule
